// ===== design/cfsu_pkg.sv =====
// shared types, widths and constants of the car-following speed update block
`timescale 1ns / 1ps

package cfsu_pkg;

   localparam int SPEED_W  = 16;           // Q8.8 speeds, factors and registers
   localparam int GAP_W    = 24;           // signed Q16.8 gap
   localparam int RND_W    = 8;            // Q0.8 random offset
   localparam int CSR_IDX_W = 3;
   localparam int ACC_W    = 24;           // per-step speed change (a*dt)>>8
   localparam int PROD_W   = 2 * SPEED_W;  // 16 x 16 product
   localparam int T1_W     = 32;           // (k*s*dt)>>16
   localparam int QUO_W    = 40;           // (phi*s*|s-p|)>>8 and its quotient
   localparam int DG_W     = SPEED_W + 1 + GAP_W;  // signed d*g
   localparam int RAD_W    = 42;           // clamped radicand
   localparam int ROOT_W   = RAD_W / 2;
   localparam int GSYNC_W  = QUO_W + 2;    // signed synchronization gap
   localparam int VEL_W    = 27;           // signed internal speeds
   localparam int LATENCY  = 3 + QUO_W + 3;  // accept edge to result edge

   localparam logic [SPEED_W-1:0] MAX_ACCEL_RST   = 16'd666;
   localparam logic [SPEED_W-1:0] MAX_DECEL_RST   = 16'd1152;
   localparam logic [SPEED_W-1:0] TAU_DECEL_RST   = 16'd1152;
   localparam logic [SPEED_W-1:0] K_FACTOR_RST    = 16'd128;
   localparam logic [SPEED_W-1:0] PHI_FACTOR_RST  = 16'd1280;
   localparam logic [SPEED_W-1:0] STEP_LENGTH_RST = 16'd256;

   // leader at rest closer than 0.01 m
   localparam logic signed [GAP_W-1:0] STOP_GAP = 24'sd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CFG_MAX_ACCEL   = 3'd0,
      CFG_MAX_DECEL   = 3'd1,
      CFG_TAU_DECEL   = 3'd2,
      CFG_K_FACTOR    = 3'd3,
      CFG_PHI_FACTOR  = 3'd4,
      CFG_STEP_LENGTH = 3'd5
   } cfg_index_type;

   // item data that rides alongside the divider
   typedef struct packed {
      logic [SPEED_W-1:0]       own;
      logic signed [GAP_W-1:0]  gap;
      logic [SPEED_W-1:0]       pred;
      logic [SPEED_W-1:0]       free;
      logic [RND_W-1:0]         rnd;
      logic                     stop;
      logic                     dneg;
      logic [T1_W-1:0]          t1;
   } side_type;

endpackage

// ===== design/cfsu_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module cfsu_div_pipe #(
   parameter int NUM_W = cfsu_pkg::QUO_W,
   parameter int DEN_W = cfsu_pkg::SPEED_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [NUM_W-1:0] in_num,
   input  logic [DEN_W-1:0] den,
   output logic             out_valid,
   output logic [NUM_W-1:0] out_quo
);

   logic [NUM_W-1:0] num_ff [NUM_W];
   logic [DEN_W-1:0] rem_ff [NUM_W];
   logic [NUM_W-1:0] vld_ff;

   genvar i;
   generate
      for (i = 0; i < NUM_W; i++) begin : g_stage
         logic [NUM_W-1:0] num_prev;
         logic [DEN_W-1:0] rem_prev;
         logic             vld_prev;
         logic [DEN_W:0]   cat;
         logic             ge;
         logic [DEN_W:0]   diff;
         logic [NUM_W-1:0] num_in;
         logic [DEN_W-1:0] rem_in;

         if (i == 0) begin : g_first
            assign num_prev = in_num;
            assign rem_prev = '0;
            assign vld_prev = in_valid;
         end else begin : g_next
            assign num_prev = num_ff[i-1];
            assign rem_prev = rem_ff[i-1];
            assign vld_prev = vld_ff[i-1];
         end

         always_comb begin
            cat    = {rem_prev, num_prev[NUM_W-1]};
            ge     = (cat >= {1'b0, den});
            diff   = cat - {1'b0, den};
            rem_in = ge ? diff[DEN_W-1:0] : cat[DEN_W-1:0];
            num_in = {num_prev[NUM_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               vld_ff[i] <= 1'b0;
            end else begin
               vld_ff[i] <= vld_prev;
            end
            num_ff[i] <= num_in;
            rem_ff[i] <= rem_in;
         end
      end
   endgenerate

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quo   = num_ff[NUM_W-1];

endmodule

// ===== design/cfsu_sqrt_pipe.sv =====
// pipelined floor square root, two radicand bits per stage
`timescale 1ns / 1ps

module cfsu_sqrt_pipe #(
   parameter int RAD_W = cfsu_pkg::RAD_W
) (
   input  logic                 clock,
   input  logic [RAD_W-1:0]     in_rad,
   output logic [RAD_W/2-1:0]   out_root
);

   localparam int ROOT_W = RAD_W / 2;
   localparam int REM_W  = ROOT_W + 2;

   logic [RAD_W-1:0]  x_ff    [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];

   genvar i;
   generate
      for (i = 0; i < ROOT_W; i++) begin : g_stage
         logic [RAD_W-1:0]  x_prev;
         logic [ROOT_W-1:0] root_prev;
         logic [REM_W-1:0]  rem_prev;
         logic [REM_W+1:0]  cat;
         logic [REM_W+1:0]  trial;
         logic              ge;
         logic [REM_W+1:0]  diff;
         logic [REM_W-1:0]  rem_in;
         logic [ROOT_W-1:0] root_in;

         if (i == 0) begin : g_first
            assign x_prev    = in_rad;
            assign root_prev = '0;
            assign rem_prev  = '0;
         end else begin : g_next
            assign x_prev    = x_ff[i-1];
            assign root_prev = root_ff[i-1];
            assign rem_prev  = rem_ff[i-1];
         end

         always_comb begin
            cat     = {rem_prev, x_prev[RAD_W-1 -: 2]};
            trial   = {{(REM_W-ROOT_W){1'b0}}, root_prev, 2'b01};
            ge      = (cat >= trial);
            diff    = cat - trial;
            rem_in  = ge ? diff[REM_W-1:0] : cat[REM_W-1:0];
            root_in = {root_prev[ROOT_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            x_ff[i]    <= {x_prev[RAD_W-3:0], 2'b00};
            root_ff[i] <= root_in;
            rem_ff[i]  <= rem_in;
         end
      end
   endgenerate

   assign out_root = root_ff[ROOT_W-1];

endmodule

// ===== design/car_following_speed_update_core.sv =====
// top level of the car-following speed update pipeline
`timescale 1ns / 1ps

// Next-speed computation for one vehicle of a three-phase car-following model.
// Request channel: an item is taken at a rising edge with start high and busy
// low; busy is low except while reset is high, so one vehicle can enter in
// every cycle. Each item carries own speed, gap, leader speed, free-road
// speed and a random offset.
// Result channel: rsp_valid marks rsp_next_speed for exactly one cycle, in
// the order the items were taken. The receiver cannot stall the pipeline.
// Path: capture, products and dividend stages, then the 40-stage restoring
// divider for the speed-difference term, with the 21-stage square root running
// beside it, then the final stages and the result register.
// Throughput: one item per cycle; every stage is registered and no stage
// ever holds an item back.
// Configuration: csr_valid/csr_ready with csr_index and csr_data, always
// ready; registers are meant to be written only while no item is in flight.
// Unknown indexes are dropped.
// Reset (synchronous, active high) restores the register defaults and empties
// the pipeline; no clearing pass is needed.

module car_following_speed_update_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [cfsu_pkg::SPEED_W-1:0]          req_own_speed,
   input  logic signed [cfsu_pkg::GAP_W-1:0]     req_gap_ahead,
   input  logic [cfsu_pkg::SPEED_W-1:0]          req_pred_speed,
   input  logic [cfsu_pkg::SPEED_W-1:0]          req_free_speed,
   input  logic [cfsu_pkg::RND_W-1:0]            req_random_offset,
   output logic                                  rsp_valid,
   output logic [cfsu_pkg::SPEED_W-1:0]          rsp_next_speed,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [cfsu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [cfsu_pkg::SPEED_W-1:0]          csr_data
);

   import cfsu_pkg::*;

   localparam int DLY_N = QUO_W - ROOT_W;  // root waits for the quotient

   // ---------------- configuration registers ----------------
   logic [SPEED_W-1:0] max_accel_ff, max_decel_ff, tau_decel_ff;
   logic [SPEED_W-1:0] k_factor_ff, phi_factor_ff, step_length_ff;
   // values derived from configuration, registered in the cycle after a write
   logic [ACC_W-1:0]   da_ff, dd_ff;
   logic [PROD_W-1:0]  tt_ff;
   logic [SPEED_W-1:0] adiv_ff;
   logic [PROD_W-1:0]  da_prod, dd_prod;

   assign busy      = reset;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_accel_ff   <= MAX_ACCEL_RST;
         max_decel_ff   <= MAX_DECEL_RST;
         tau_decel_ff   <= TAU_DECEL_RST;
         k_factor_ff    <= K_FACTOR_RST;
         phi_factor_ff  <= PHI_FACTOR_RST;
         step_length_ff <= STEP_LENGTH_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CFG_MAX_ACCEL:   max_accel_ff   <= csr_data;
            CFG_MAX_DECEL:   max_decel_ff   <= csr_data;
            CFG_TAU_DECEL:   tau_decel_ff   <= csr_data;
            CFG_K_FACTOR:    k_factor_ff    <= csr_data;
            CFG_PHI_FACTOR:  phi_factor_ff  <= csr_data;
            CFG_STEP_LENGTH: step_length_ff <= csr_data;
            default: ;  // unknown index, dropped
         endcase
      end
   end

   assign da_prod = max_accel_ff * step_length_ff;
   assign dd_prod = max_decel_ff * step_length_ff;

   always_ff @(posedge clock) begin
      da_ff   <= da_prod[PROD_W-1:8];
      dd_ff   <= dd_prod[PROD_W-1:8];
      tt_ff   <= tau_decel_ff * tau_decel_ff;
      // zero acceleration divides as one
      adiv_ff <= (max_accel_ff == '0) ? SPEED_W'(1) : max_accel_ff;
   end

   // ---------------- stage 1: capture the request ----------------
   logic                      s1_valid_ff;
   logic [SPEED_W-1:0]        s1_own_ff, s1_pred_ff, s1_free_ff;
   logic signed [GAP_W-1:0]   s1_gap_ff;
   logic [RND_W-1:0]          s1_rnd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= start && !busy;
      end
      s1_own_ff  <= req_own_speed;
      s1_gap_ff  <= req_gap_ahead;
      s1_pred_ff <= req_pred_speed;
      s1_free_ff <= req_free_speed;
      s1_rnd_ff  <= req_random_offset;
   end

   // ---------------- stage 2: first products ----------------
   logic                      s2_valid_ff;
   logic [SPEED_W-1:0]        s2_own_ff, s2_pred_ff, s2_free_ff;
   logic signed [GAP_W-1:0]   s2_gap_ff;
   logic [RND_W-1:0]          s2_rnd_ff;
   logic                      s2_stop_ff, s2_dneg_ff;
   logic [PROD_W-1:0]         s2_ks_ff, s2_ps_ff, s2_pp_ff;
   logic [SPEED_W-1:0]        s2_mag_ff;
   logic signed [DG_W-1:0]    s2_dg_ff;
   logic                      s2_dneg_in;
   logic [SPEED_W-1:0]        s2_mag_in;

   always_comb begin
      s2_dneg_in = (s1_own_ff < s1_pred_ff);
      s2_mag_in  = s2_dneg_in ? (s1_pred_ff - s1_own_ff) : (s1_own_ff - s1_pred_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_own_ff  <= s1_own_ff;
      s2_gap_ff  <= s1_gap_ff;
      s2_pred_ff <= s1_pred_ff;
      s2_free_ff <= s1_free_ff;
      s2_rnd_ff  <= s1_rnd_ff;
      s2_stop_ff <= (s1_pred_ff == '0) && (s1_gap_ff < STOP_GAP);
      s2_dneg_ff <= s2_dneg_in;
      s2_mag_ff  <= s2_mag_in;
      s2_ks_ff   <= k_factor_ff * s1_own_ff;
      s2_ps_ff   <= phi_factor_ff * s1_own_ff;
      s2_pp_ff   <= s1_pred_ff * s1_pred_ff;
      s2_dg_ff   <= $signed({1'b0, max_decel_ff}) * s1_gap_ff;
   end

   // ---------------- stage 3: dividend, sync term, radicand ----------------
   logic                      s3_valid_ff;
   side_type                  s3_side_ff;
   logic [QUO_W-1:0]          s3_num_ff;
   logic [RAD_W-1:0]          s3_rad_ff;
   logic [PROD_W+SPEED_W-1:0] s3_t1_prod, s3_num_prod;
   logic signed [RAD_W:0]     s3_rad_sum;

   always_comb begin
      s3_t1_prod  = s2_ks_ff * step_length_ff;
      s3_num_prod = s2_ps_ff * s2_mag_ff;
      s3_rad_sum  = $signed({{(RAD_W+1-PROD_W){1'b0}}, tt_ff})
                  + $signed({{(RAD_W+1-PROD_W){1'b0}}, s2_pp_ff})
                  + ($signed({{(RAD_W+1-DG_W){s2_dg_ff[DG_W-1]}}, s2_dg_ff}) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      s3_side_ff.own  <= s2_own_ff;
      s3_side_ff.gap  <= s2_gap_ff;
      s3_side_ff.pred <= s2_pred_ff;
      s3_side_ff.free <= s2_free_ff;
      s3_side_ff.rnd  <= s2_rnd_ff;
      s3_side_ff.stop <= s2_stop_ff;
      s3_side_ff.dneg <= s2_dneg_ff;
      s3_side_ff.t1   <= s3_t1_prod[PROD_W+SPEED_W-1:16];
      s3_num_ff       <= s3_num_prod[QUO_W+7:8];
      // negative radicand clamps to zero
      s3_rad_ff       <= s3_rad_sum[RAD_W] ? '0 : s3_rad_sum[RAD_W-1:0];
   end

   // ---------------- divider and square root ----------------
   logic              div_valid;
   logic [QUO_W-1:0]  div_quo;
   logic [ROOT_W-1:0] sq_root;

   cfsu_div_pipe #(
      .NUM_W (QUO_W),
      .DEN_W (SPEED_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_num    (s3_num_ff),
      .den       (adiv_ff),
      .out_valid (div_valid),
      .out_quo   (div_quo)
   );

   cfsu_sqrt_pipe #(
      .RAD_W (RAD_W)
   ) u_sqrt (
      .clock    (clock),
      .in_rad   (s3_rad_ff),
      .out_root (sq_root)
   );

   // item data and root travel beside the divider
   side_type          side_ff [QUO_W];
   logic [ROOT_W-1:0] root_dly_ff [DLY_N];

   always_ff @(posedge clock) begin
      side_ff[0]     <= s3_side_ff;
      root_dly_ff[0] <= sq_root;
      for (int j = 1; j < QUO_W; j++) begin
         side_ff[j] <= side_ff[j-1];
      end
      for (int j = 1; j < DLY_N; j++) begin
         root_dly_ff[j] <= root_dly_ff[j-1];
      end
   end

   // ---------------- final 1: sync gap, conditional and safe speed ----------
   side_type                  dv;
   logic signed [GSYNC_W-1:0] f1_sum, f1_gsync, f1_gap_ext;
   logic signed [VEL_W-1:0]   f1_own, f1_da, f1_dd, f1_sda, f1_pms, f1_lim, f1_lo;
   logic signed [VEL_W-1:0]   f1_vcond_in, f1_vsafe_in;

   logic                      f1_valid_ff, f1_stop_ff;
   logic signed [VEL_W-1:0]   f1_vcond_ff, f1_vsafe_ff, f1_sda_ff, f1_free_ff;
   logic [RND_W-1:0]          f1_rnd_ff;

   always_comb begin
      dv         = side_ff[QUO_W-1];
      f1_sum     = dv.dneg
                 ? ($signed({{(GSYNC_W-T1_W){1'b0}}, dv.t1})
                    - $signed({{(GSYNC_W-QUO_W){1'b0}}, div_quo}))
                 : ($signed({{(GSYNC_W-T1_W){1'b0}}, dv.t1})
                    + $signed({{(GSYNC_W-QUO_W){1'b0}}, div_quo}));
      f1_gsync   = f1_sum[GSYNC_W-1] ? '0 : f1_sum;
      f1_gap_ext = {{(GSYNC_W-GAP_W){dv.gap[GAP_W-1]}}, dv.gap};
      f1_own     = $signed({{(VEL_W-SPEED_W){1'b0}}, dv.own});
      f1_da      = $signed({{(VEL_W-ACC_W){1'b0}}, da_ff});
      f1_dd      = $signed({{(VEL_W-ACC_W){1'b0}}, dd_ff});
      f1_sda     = f1_own + f1_da;
      f1_pms     = $signed({{(VEL_W-SPEED_W){1'b0}}, dv.pred}) - f1_own;
      f1_lim     = (f1_da < f1_pms) ? f1_da : f1_pms;
      f1_lo      = (-f1_dd > f1_lim) ? -f1_dd : f1_lim;
      // free flow beyond the synchronization gap, else follow the leader
      f1_vcond_in = (f1_gap_ext > f1_gsync) ? f1_sda : (f1_own + f1_lo);
      f1_vsafe_in = $signed({{(VEL_W-ROOT_W){1'b0}}, root_dly_ff[DLY_N-1]})
                  - $signed({{(VEL_W-SPEED_W){1'b0}}, tau_decel_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff <= div_valid;
      end
      f1_stop_ff  <= dv.stop;
      f1_vcond_ff <= f1_vcond_in;
      f1_vsafe_ff <= f1_vsafe_in;
      f1_sda_ff   <= f1_sda;
      f1_free_ff  <= $signed({{(VEL_W-SPEED_W){1'b0}}, dv.free});
      f1_rnd_ff   <= dv.rnd;
   end

   // ---------------- final 2: perturbed speed and upper bound ----------------
   logic signed [VEL_W-1:0] f2_m1, f2_m1c, f2_m2;
   logic                    f2_valid_ff, f2_stop_ff;
   logic signed [VEL_W-1:0] f2_va_ff, f2_m2_ff;

   always_comb begin
      f2_m1  = (f1_vsafe_ff < f1_vcond_ff) ? f1_vsafe_ff : f1_vcond_ff;
      f2_m1  = (f1_free_ff < f2_m1) ? f1_free_ff : f2_m1;
      f2_m1c = f2_m1[VEL_W-1] ? '0 : f2_m1;
      f2_m2  = (f1_sda_ff < f1_vsafe_ff) ? f1_sda_ff : f1_vsafe_ff;
      f2_m2  = (f1_free_ff < f2_m2) ? f1_free_ff : f2_m2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_valid_ff <= 1'b0;
      end else begin
         f2_valid_ff <= f1_valid_ff;
      end
      f2_stop_ff <= f1_stop_ff;
      f2_va_ff   <= f2_m1c + $signed({{(VEL_W-RND_W){1'b0}}, f1_rnd_ff});
      f2_m2_ff   <= f2_m2;
   end

   // ---------------- final 3: clamp, saturate, result register ----------------
   logic signed [VEL_W-1:0] f3_v;
   logic [SPEED_W-1:0]      f3_speed;
   logic                    rsp_valid_ff;
   logic [SPEED_W-1:0]      rsp_speed_ff;

   always_comb begin
      f3_v = (f2_va_ff < f2_m2_ff) ? f2_va_ff : f2_m2_ff;
      if (f2_stop_ff || f3_v[VEL_W-1]) begin
         f3_speed = '0;
      end else if (f3_v > $signed({{(VEL_W-SPEED_W){1'b0}}, {SPEED_W{1'b1}}})) begin
         f3_speed = '1;
      end else begin
         f3_speed = f3_v[SPEED_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= f2_valid_ff;
      end
      rsp_speed_ff <= f3_speed;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_next_speed = rsp_speed_ff;

endmodule

// ===== design/cfsu_checker.sv =====
// port-level checks of the speed update core and their bind
`timescale 1ns / 1ps

module cfsu_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic signed [cfsu_pkg::GAP_W-1:0] req_gap_ahead,
   input logic [cfsu_pkg::SPEED_W-1:0]      req_pred_speed,
   input logic [cfsu_pkg::SPEED_W-1:0]      req_free_speed,
   input logic                              rsp_valid,
   input logic [cfsu_pkg::SPEED_W-1:0]      rsp_next_speed
);

   import cfsu_pkg::*;

   localparam int PAST_N = LATENCY;

   // every result comes from a transfer a fixed latency earlier
   a_result_has_request : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, PAST_N))
      else $error("result without a matching request transfer");

   // an accepted request always yields a result after the latency
   a_request_gives_result : assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !$past(reset, 1)) |-> ##LATENCY
         (rsp_valid || $past(reset, LATENCY - 1)))
      else $error("request transfer produced no result");

   // leader at rest within the stop distance gives zero speed
   a_stop_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ($past(req_pred_speed, PAST_N) == '0)
                 && ($past(req_gap_ahead, PAST_N) < STOP_GAP))
      |-> (rsp_next_speed == '0))
      else $error("stop request did not give zero speed");

   // next speed never exceeds the free-road limit
   a_free_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_next_speed <= $past(req_free_speed, PAST_N)))
      else $error("next speed above free-road limit");

endmodule

bind car_following_speed_update_core cfsu_checker u_cfsu_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_gap_ahead  (req_gap_ahead),
   .req_pred_speed (req_pred_speed),
   .req_free_speed (req_free_speed),
   .rsp_valid      (rsp_valid),
   .rsp_next_speed (rsp_next_speed)
);

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the car-following speed update core
`timescale 1ns / 1ps

module tb_top;
   import cfsu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int RANDOM_ITEMS   = 1500;

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic [SPEED_W-1:0]          req_own_speed;
   logic signed [GAP_W-1:0]     req_gap_ahead;
   logic [SPEED_W-1:0]          req_pred_speed;
   logic [SPEED_W-1:0]          req_free_speed;
   logic [RND_W-1:0]            req_random_offset;
   logic                        rsp_valid;
   logic [SPEED_W-1:0]          rsp_next_speed;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_IDX_W-1:0]        csr_index;
   logic [SPEED_W-1:0]          csr_data;

   car_following_speed_update_core DUT (.*);

   // register shadow used by the predictor
   logic [15:0] sh_accel, sh_decel, sh_tau, sh_k, sh_phi, sh_dt;

   logic [15:0] speed_queue[$];
   int          error_count = 0;
   int          idle_cycles = 0;

   typedef struct {
      logic [15:0] own;
      logic [23:0] gap;
      logic [15:0] pred;
      logic [15:0] free;
      logic [7:0]  rnd;
      int          known;   // -1 when the predictor decides
   } vehicle_row;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // floor square root, bit by bit
   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits >>= 2;
      while (bits != 0) begin
         if (v >= res + bits) begin
            v -= res + bits;
            res = (res >> 1) + bits;
         end else begin
            res >>= 1;
         end
         bits >>= 2;
      end
      return res;
   endfunction

   function automatic longint smaller(longint x, longint y);
      return x < y ? x : y;
   endfunction

   function automatic longint larger(longint x, longint y);
      return x > y ? x : y;
   endfunction

   function automatic logic [15:0] next_speed_of(logic [15:0] own, logic [23:0] gap_raw,
                                                 logic [15:0] pred, logic [15:0] free,
                                                 logic [7:0] rnd);
      longint s, g, p, f, r, da, dd, t1, diff, q, t2, gsync, vcond, rad, vsafe, va, v, tt;
      longint unsigned adiv, mag;
      s = own; p = pred; f = free; r = rnd;
      g = longint'($signed(gap_raw));
      // leader at rest and gap under one hundredth of a metre
      if (p == 0 && g < 3) return 16'd0;
      da = longint'((64'(sh_accel) * sh_dt) >> 8);
      dd = longint'((64'(sh_decel) * sh_dt) >> 8);
      // zero acceleration only matters in the divisor
      adiv = sh_accel == 0 ? 64'd1 : 64'(sh_accel);
      t1 = longint'((64'(sh_k) * 64'(s) * sh_dt) >> 16);
      diff = s - p;
      mag = diff < 0 ? -diff : diff;
      q = longint'((64'(sh_phi) * 64'(s) * mag) / (adiv << 8));
      t2 = diff < 0 ? -q : q;
      gsync = larger(0, t1 + t2);
      if (g > gsync) vcond = s + da;
      else vcond = s + larger(-dd, smaller(da, p - s));
      tt = sh_tau;
      rad = tt * tt + p * p + 2 * longint'(sh_decel) * g;
      if (rad < 0) rad = 0;
      vsafe = longint'(floor_root(rad)) - tt;
      va = larger(0, smaller(f, smaller(vsafe, vcond))) + r;
      v = larger(0, smaller(smaller(f, va), smaller(s + da, vsafe)));
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   // one request transfer; the prediction goes in at the accept edge
   task automatic send_vehicle(vehicle_row row);
      start             <= 1'b1;
      req_own_speed     <= row.own;
      req_gap_ahead     <= row.gap;
      req_pred_speed    <= row.pred;
      req_free_speed    <= row.free;
      req_random_offset <= row.rnd;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (row.known >= 0) speed_queue.push_back(16'(row.known));
      else speed_queue.push_back(next_speed_of(row.own, row.gap, row.pred, row.free, row.rnd));
   endtask

   task automatic sender_gap();
      int n;
      n = ($urandom_range(0, 99) < 60) ? 0 :
          ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 80);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // wait until every expected result is in, then let the pipeline drain
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (speed_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   // csr_valid stays high for back-to-back writes; the caller drops it
   task automatic write_register(cfg_index_type idx, logic [15:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CFG_MAX_ACCEL:   sh_accel = val;
         CFG_MAX_DECEL:   sh_decel = val;
         CFG_TAU_DECEL:   sh_tau   = val;
         CFG_K_FACTOR:    sh_k     = val;
         CFG_PHI_FACTOR:  sh_phi   = val;
         CFG_STEP_LENGTH: sh_dt    = val;
         default: ;
      endcase
   endtask

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(1, 32));
         default: return 16'($urandom);
      endcase
   endfunction

   // mostly realistic traffic with some raw noise
   function automatic vehicle_row random_vehicle();
      vehicle_row row;
      row.known = -1;
      row.rnd = 8'($urandom);
      if ($urandom_range(0, 99) < 70) begin
         row.own  = 16'($urandom_range(0, 40 * 256));
         row.pred = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(0, 40 * 256));
         row.free = 16'($urandom_range(0, 45 * 256));
         case ($urandom_range(0, 3))
            0: row.gap = 24'($urandom_range(0, 8));
            1: row.gap = 24'($urandom_range(0, 256 * 200));
            2: row.gap = -24'($urandom_range(1, 256 * 50));
            default: row.gap = 24'($urandom_range(0, 256 * 20));
         endcase
      end else begin
         row.own = pick16(); row.pred = pick16(); row.free = pick16();
         row.gap = 24'($urandom);
      end
      return row;
   endfunction

   task automatic random_config();
      write_register(CFG_MAX_ACCEL,   $urandom_range(0, 3) == 0 ? pick16() | 16'd1
                                      : 16'($urandom_range(1, 1024)));
      write_register(CFG_MAX_DECEL,   $urandom_range(0, 3) == 0 ? pick16() | 16'd1
                                      : 16'($urandom_range(1, 2048)));
      write_register(CFG_TAU_DECEL,   $urandom_range(0, 3) == 0 ? pick16()
                                      : 16'($urandom_range(0, 2048)));
      write_register(CFG_K_FACTOR,    $urandom_range(0, 3) == 0 ? pick16()
                                      : 16'($urandom_range(0, 512)));
      write_register(CFG_PHI_FACTOR,  $urandom_range(0, 3) == 0 ? pick16()
                                      : 16'($urandom_range(0, 2560)));
      write_register(CFG_STEP_LENGTH, $urandom_range(0, 3) == 0 ? pick16() | 16'd1
                                      : 16'($urandom_range(64, 512)));
      csr_valid <= 1'b0;
   endtask

   // result check; the receiver takes every strobed result
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (speed_queue.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual next_speed %0d",
                     $time, rsp_next_speed);
            error_count++;
         end else begin
            logic [15:0] want;
            want = speed_queue.pop_front();
            if (rsp_next_speed !== want) begin
               $display("%0t: next_speed mismatch, expected %0d, actual %0d",
                        $time, want, rsp_next_speed);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   vehicle_row directed[] = '{
      // stop cases: leader at rest, gap under the threshold
      '{16'd1000, 24'd2,        16'd0,      16'd5000,  8'd200, 0},
      '{16'hFFFF, 24'h800000,   16'd0,      16'hFFFF,  8'hFF,  0},
      '{16'd0,    24'd0,        16'd0,      16'd0,     8'd0,   0},
      // leader at rest just at the threshold
      '{16'd1000, 24'd3,        16'd0,      16'd5000,  8'd0,   -1},
      // negative radicand clamps to zero
      '{16'd500,  24'h800000,   16'd100,    16'd5000,  8'd50,  -1},
      // free road with a far leader, then mixed gaps and speeds
      '{16'd2560, 24'h7FFFFF,   16'd2560,   16'd3000,  8'd10,  -1},
      '{16'hFFFF, 24'h7FFFFF,   16'hFFFF,   16'hFFFF,  8'hFF,  -1},
      '{16'd0,    24'h7FFFFF,   16'hFFFF,   16'hFFFF,  8'hFF,  -1},
      '{16'hFFFF, 24'd1,        16'd1,      16'hFFFF,  8'd0,   -1},
      '{16'd0,    24'hFFFFFF,   16'd1,      16'd0,     8'd128, -1},
      '{16'd3000, 24'd2000,     16'd1000,   16'd4000,  8'd77,  -1},
      '{16'd1000, 24'd2000,     16'd3000,   16'd4000,  8'd1,   -1},
      '{16'h5555, 24'h555555,   16'hAAAA,   16'h5555,  8'h55,  -1},
      '{16'hAAAA, 24'hAAAAAA,   16'h5555,   16'hAAAA,  8'hAA,  -1}
   };

   initial begin
      vehicle_row row;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_own_speed = '0;
      req_gap_ahead = '0;
      req_pred_speed = '0;
      req_free_speed = '0;
      req_random_offset = '0;
      sh_accel = MAX_ACCEL_RST;  sh_decel = MAX_DECEL_RST; sh_tau = TAU_DECEL_RST;
      sh_k = K_FACTOR_RST;       sh_phi = PHI_FACTOR_RST;  sh_dt = STEP_LENGTH_RST;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table under reset defaults, then under extreme settings
      for (int pass = 0; pass < 3; pass++) begin
         if (pass == 1) begin
            write_register(CFG_MAX_ACCEL, 16'd1);   write_register(CFG_MAX_DECEL, 16'd1);
            write_register(CFG_TAU_DECEL, 16'd0);   write_register(CFG_K_FACTOR, 16'd0);
            write_register(CFG_PHI_FACTOR, 16'd0);  write_register(CFG_STEP_LENGTH, 16'd1);
            csr_valid <= 1'b0;
         end else if (pass == 2) begin
            write_register(CFG_MAX_ACCEL, 16'hFFFF);   write_register(CFG_MAX_DECEL, 16'hFFFF);
            write_register(CFG_TAU_DECEL, 16'hFFFF);   write_register(CFG_K_FACTOR, 16'hFFFF);
            write_register(CFG_PHI_FACTOR, 16'hFFFF);  write_register(CFG_STEP_LENGTH, 16'hFFFF);
            csr_valid <= 1'b0;
         end
         foreach (directed[i]) begin
            send_vehicle(directed[i]);
            sender_gap();
         end
         // sender holds off until everything is back
         drain();
      end

      // random phases, fresh registers in between
      for (int phase = 0; phase < 6; phase++) begin
         random_config();
         for (int n = 0; n < RANDOM_ITEMS / 6; n++) begin
            row = random_vehicle();
            send_vehicle(row);
            if (phase != 2) sender_gap();
         end
         drain();
      end

      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== filelist.f =====
design/cfsu_pkg.sv
design/cfsu_div_pipe.sv
design/cfsu_sqrt_pipe.sv
design/car_following_speed_update_core.sv
design/cfsu_checker.sv
tb/sv/tb_top.sv
